FILE: src/llcp_pkg.sv
package llcp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int TOL_W       = 32;

    // A coordinate difference needs one more bit than a coordinate.
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PP_W    = 2 * DIFF_W;
    // A sum of three products of differences needs two more bits.
    localparam int DOT_W   = PP_W + 2;
    localparam int HALF_W  = DOT_W / 2;
    localparam int WIDE_W  = 2 * DOT_W;
    localparam int CHUNK_W = WIDE_W / 4;
    localparam int PROD_W  = WIDE_W + DIFF_W + 1;
    localparam int QUO_W   = COORD_WIDTH + 1;
    localparam int NUM_W   = PROD_W + 2;
    localparam int DVS_W   = WIDE_W;
    localparam int DIV_LAT = QUO_W + 1;
    localparam int CMP_W   = DIFF_W + TOL_W;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [DOT_W-1:0]       t_dot;
    typedef logic signed [WIDE_W-1:0]      t_wide;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_B_DEGEN  = 2'd1,
        ST_A_DEGEN  = 2'd2,
        ST_PARALLEL = 2'd3
    } t_status;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_start_z;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord a_end_z;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_start_z;
        t_coord b_end_x;
        t_coord b_end_y;
        t_coord b_end_z;
    } t_in_item;

    typedef struct packed {
        t_status status;
        t_coord  param_a;
        t_coord  param_b;
        t_coord  near_a_x;
        t_coord  near_a_y;
        t_coord  near_a_z;
        t_coord  near_b_x;
        t_coord  near_b_y;
        t_coord  near_b_z;
    } t_out_item;

    typedef struct packed {
        t_dot d1343;
        t_dot d4321;
        t_dot d1321;
        t_dot d4343;
        t_dot d2121;
    } t_dots;

    typedef struct packed {
        logic             ovf;
        logic [QUO_W-1:0] q;
    } t_quo;

    function automatic t_diff f_diff(input t_coord a, input t_coord b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [DIFF_W-1:0] f_abs(input t_diff d);
        return d[DIFF_W-1] ? unsigned'(-d) : unsigned'(d);
    endfunction

endpackage

FILE: src/line_line_closest_points.sv
// Channel   Direction  Handshake                  Payload
// item      in         start high, busy low       i_item (t_in_item)
// result    out        o_valid, one cycle         o_result (t_out_item)
// config    in         i_cfg_we                   i_cfg_data (tolerance)
//
// One item is accepted in every cycle; busy is always low.
// After the accepting edge an item passes through the dot products, two wide
// multiply stages, the numerators and a second multiply, the divider operands,
// the 34-stage restoring divider and the output register that drives o_valid.
// Reset clears the valid chain and sets the tolerance to one. Nothing stalls:
// the receiver must take a result in the cycle it is shown; nothing enforces it.
module line_line_closest_points import llcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_data,
    output logic             o_valid,
    output t_out_item        o_result
);

    localparam int DIV_AT = 10 + DIV_LAT;

    localparam logic signed [COORD_WIDTH+2:0] MAX_V = {3'b000, 1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH+2:0] MIN_V = {3'b111, 1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [TOL_W-1:0] r_tol;
    logic             r_vld [1:DIV_AT];
    t_in_item         r_item_d [1:DIV_AT];
    t_status          r_stat [4:DIV_AT];
    logic [7:0]       r_sgn [7:DIV_AT];

    t_dots   w_dots;
    t_status w_dots_st;
    t_wide   w_m [6];

    t_wide r_den;
    t_wide r_na;
    t_wide r_nb;

    logic [WIDE_W-1:0] w_den_mag;
    logic              w_par;
    t_diff             w_d6 [6];
    logic [WIDE_W-1:0] r_den_mag7;
    logic [WIDE_W-1:0] r_na_mag7;
    logic [WIDE_W-1:0] r_nb_mag7;
    logic [DIFF_W-1:0] r_dmag7 [6];

    logic [PROD_W-1:0] w_pm [6];
    logic [PROD_W-1:0] r_pnum8 [2];
    logic [PROD_W-1:0] r_pnum9 [2];
    logic [WIDE_W-1:0] r_den_mag8;
    logic [WIDE_W-1:0] r_den_mag9;

    logic [NUM_W-1:0]  r_num [8];
    logic [DVS_W-1:0]  r_dvs;
    t_quo              w_quo [8];

    t_out_item n_out;
    t_out_item r_out;
    logic      r_done;

    function automatic t_coord f_sat(input t_coord s, input t_quo r, input logic neg);
        logic signed [COORD_WIDTH+2:0] v_s;
        logic signed [COORD_WIDTH+2:0] v_q;
        logic signed [COORD_WIDTH+2:0] v;
        v_s = (COORD_WIDTH + 3)'(s);
        v_q = signed'({2'b00, r.q});
        v   = neg ? v_s - v_q : v_s + v_q;
        if (r.ovf) begin
            return neg ? MIN_V[COORD_WIDTH-1:0] : MAX_V[COORD_WIDTH-1:0];
        end else if (v > MAX_V) begin
            return MAX_V[COORD_WIDTH-1:0];
        end else if (v < MIN_V) begin
            return MIN_V[COORD_WIDTH-1:0];
        end else begin
            return v[COORD_WIDTH-1:0];
        end
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(1);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= DIV_AT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_vld[1] <= start;
            for (int k = 2; k <= DIV_AT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_done <= r_vld[DIV_AT];
        end
    end

    llcp_dots u_dots (
        .i_clk    (i_clk),
        .i_item   (i_item),
        .i_tol    (r_tol),
        .o_dots   (w_dots),
        .o_status (w_dots_st)
    );

    llcp_wmul u_m0 (.i_clk(i_clk), .i_a(w_dots.d2121), .i_b(w_dots.d4343), .o_p(w_m[0]));
    llcp_wmul u_m1 (.i_clk(i_clk), .i_a(w_dots.d4321), .i_b(w_dots.d4321), .o_p(w_m[1]));
    llcp_wmul u_m2 (.i_clk(i_clk), .i_a(w_dots.d1343), .i_b(w_dots.d4321), .o_p(w_m[2]));
    llcp_wmul u_m3 (.i_clk(i_clk), .i_a(w_dots.d1321), .i_b(w_dots.d4343), .o_p(w_m[3]));
    llcp_wmul u_m4 (.i_clk(i_clk), .i_a(w_dots.d1343), .i_b(w_dots.d2121), .o_p(w_m[4]));
    llcp_wmul u_m5 (.i_clk(i_clk), .i_a(w_dots.d4321), .i_b(w_dots.d1321), .o_p(w_m[5]));

    always_comb begin
        w_den_mag = r_den[WIDE_W-1] ? unsigned'(-r_den) : unsigned'(r_den);
        // Near-parallel compares the denominator magnitude with the tolerance shifted left by 3*FRAC_BITS.
        w_par = (r_den == '0) || (w_den_mag < (WIDE_W'(r_tol) << (3 * FRAC_BITS)));
        w_d6[0] = f_diff(r_item_d[6].a_end_x, r_item_d[6].a_start_x);
        w_d6[1] = f_diff(r_item_d[6].a_end_y, r_item_d[6].a_start_y);
        w_d6[2] = f_diff(r_item_d[6].a_end_z, r_item_d[6].a_start_z);
        w_d6[3] = f_diff(r_item_d[6].b_end_x, r_item_d[6].b_start_x);
        w_d6[4] = f_diff(r_item_d[6].b_end_y, r_item_d[6].b_start_y);
        w_d6[5] = f_diff(r_item_d[6].b_end_z, r_item_d[6].b_start_z);
    end

    always_ff @(posedge i_clk) begin
        r_item_d[1] <= i_item;
        for (int k = 2; k <= DIV_AT; k++) begin
            r_item_d[k] <= r_item_d[k-1];
        end
        r_stat[4] <= w_dots_st;
        r_stat[5] <= r_stat[4];
        r_stat[6] <= r_stat[5];
        r_stat[7] <= (r_stat[6] == ST_OK && w_par) ? ST_PARALLEL : r_stat[6];
        for (int k = 8; k <= DIV_AT; k++) begin
            r_stat[k] <= r_stat[k-1];
        end

        r_den <= w_m[0] - w_m[1];
        r_na  <= w_m[2] - w_m[3];
        r_nb  <= w_m[4] - w_m[5];

        r_den_mag7 <= w_den_mag;
        r_na_mag7  <= r_na[WIDE_W-1] ? unsigned'(-r_na) : unsigned'(r_na);
        r_nb_mag7  <= r_nb[WIDE_W-1] ? unsigned'(-r_nb) : unsigned'(r_nb);
        for (int i = 0; i < 6; i++) begin
            r_dmag7[i] <= f_abs(w_d6[i]);
        end
        r_sgn[7][0] <= r_na[WIDE_W-1] ^ r_den[WIDE_W-1];
        r_sgn[7][1] <= r_nb[WIDE_W-1] ^ r_den[WIDE_W-1];
        for (int i = 0; i < 3; i++) begin
            r_sgn[7][2 + i] <= r_na[WIDE_W-1] ^ r_den[WIDE_W-1] ^ w_d6[i][DIFF_W-1];
            r_sgn[7][5 + i] <= r_nb[WIDE_W-1] ^ r_den[WIDE_W-1] ^ w_d6[3 + i][DIFF_W-1];
        end
        for (int k = 8; k <= DIV_AT; k++) begin
            r_sgn[k] <= r_sgn[k-1];
        end

        r_pnum8[0] <= PROD_W'(r_na_mag7) << FRAC_BITS;
        r_pnum8[1] <= PROD_W'(r_nb_mag7) << FRAC_BITS;
        r_pnum9    <= r_pnum8;
        r_den_mag8 <= r_den_mag7;
        r_den_mag9 <= r_den_mag8;

        // Rounding to nearest: floor((2|n| + |d|) / (2|d|)).
        for (int j = 0; j < 2; j++) begin
            r_num[j] <= (NUM_W'(r_pnum9[j]) << 1) + NUM_W'(r_den_mag9);
        end
        for (int j = 0; j < 6; j++) begin
            r_num[2 + j] <= (NUM_W'(w_pm[j]) << 1) + NUM_W'(r_den_mag9);
        end
        r_dvs <= {r_den_mag9[WIDE_W-2:0], 1'b0};

        r_out <= n_out;
    end

    genvar g;
    generate
        for (g = 0; g < 6; g++) begin : g_pmul
            llcp_pmul u_pmul (
                .i_clk (i_clk),
                .i_a   ((g < 3) ? r_na_mag7 : r_nb_mag7),
                .i_b   (r_dmag7[g]),
                .o_p   (w_pm[g])
            );
        end
        for (g = 0; g < 8; g++) begin : g_div
            llcp_div u_div (
                .i_clk (i_clk),
                .i_num (r_num[g]),
                .i_dvs (r_dvs),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    always_comb begin
        n_out = '0;
        n_out.status = r_stat[DIV_AT];
        if (r_stat[DIV_AT] == ST_OK) begin
            n_out.param_a  = f_sat('0, w_quo[0], r_sgn[DIV_AT][0]);
            n_out.param_b  = f_sat('0, w_quo[1], r_sgn[DIV_AT][1]);
            n_out.near_a_x = f_sat(r_item_d[DIV_AT].a_start_x, w_quo[2], r_sgn[DIV_AT][2]);
            n_out.near_a_y = f_sat(r_item_d[DIV_AT].a_start_y, w_quo[3], r_sgn[DIV_AT][3]);
            n_out.near_a_z = f_sat(r_item_d[DIV_AT].a_start_z, w_quo[4], r_sgn[DIV_AT][4]);
            n_out.near_b_x = f_sat(r_item_d[DIV_AT].b_start_x, w_quo[5], r_sgn[DIV_AT][5]);
            n_out.near_b_y = f_sat(r_item_d[DIV_AT].b_start_y, w_quo[6], r_sgn[DIV_AT][6]);
            n_out.near_b_z = f_sat(r_item_d[DIV_AT].b_start_z, w_quo[7], r_sgn[DIV_AT][7]);
        end
    end

    assign o_valid  = r_done;
    assign o_result = r_out;

    a_valid_follows_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, DIV_AT + 1)
    ) else $error("result beat without a matching accepted item");

    a_status_zeroes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |->
            (o_result.param_a == '0 && o_result.param_b == '0 &&
             o_result.near_a_x == '0 && o_result.near_b_z == '0)
    ) else $error("non-ok result beat carries nonzero fields");

    a_chain_matches: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_vld[DIV_AT] |=> o_valid
    ) else $error("valid chain lost a beat at the output register");

endmodule

FILE: src/llcp_dots.sv
module llcp_dots import llcp_pkg::*; (
    input  logic             i_clk,
    input  t_in_item         i_item,
    input  logic [TOL_W-1:0] i_tol,
    output t_dots            o_dots,
    output t_status          o_status
);

    t_diff r_d13 [3];
    t_diff r_d43 [3];
    t_diff r_d21 [3];
    logic signed [PP_W-1:0] r_p [15];
    t_status r_st2;
    t_dots   r_dots;
    t_status r_st3;

    t_diff   w_d13 [3];
    t_diff   w_d43 [3];
    t_diff   w_d21 [3];
    logic    w_b_small;
    logic    w_a_small;
    t_status n_st2;

    always_comb begin
        w_d13[0] = f_diff(i_item.a_start_x, i_item.b_start_x);
        w_d13[1] = f_diff(i_item.a_start_y, i_item.b_start_y);
        w_d13[2] = f_diff(i_item.a_start_z, i_item.b_start_z);
        w_d43[0] = f_diff(i_item.b_end_x, i_item.b_start_x);
        w_d43[1] = f_diff(i_item.b_end_y, i_item.b_start_y);
        w_d43[2] = f_diff(i_item.b_end_z, i_item.b_start_z);
        w_d21[0] = f_diff(i_item.a_end_x, i_item.a_start_x);
        w_d21[1] = f_diff(i_item.a_end_y, i_item.a_start_y);
        w_d21[2] = f_diff(i_item.a_end_z, i_item.a_start_z);
    end

    // A line is degenerate when every component of its direction is below tolerance.
    always_comb begin
        w_b_small = 1'b1;
        w_a_small = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (CMP_W'(f_abs(r_d43[i])) >= CMP_W'(i_tol)) begin
                w_b_small = 1'b0;
            end
            if (CMP_W'(f_abs(r_d21[i])) >= CMP_W'(i_tol)) begin
                w_a_small = 1'b0;
            end
        end
        if (w_b_small) begin
            n_st2 = ST_B_DEGEN;
        end else if (w_a_small) begin
            n_st2 = ST_A_DEGEN;
        end else begin
            n_st2 = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d13[i] <= w_d13[i];
            r_d43[i] <= w_d43[i];
            r_d21[i] <= w_d21[i];
            r_p[i]      <= r_d13[i] * r_d43[i];
            r_p[3 + i]  <= r_d43[i] * r_d21[i];
            r_p[6 + i]  <= r_d13[i] * r_d21[i];
            r_p[9 + i]  <= r_d43[i] * r_d43[i];
            r_p[12 + i] <= r_d21[i] * r_d21[i];
        end
        r_st2 <= n_st2;
        r_dots.d1343 <= DOT_W'(r_p[0]) + DOT_W'(r_p[1]) + DOT_W'(r_p[2]);
        r_dots.d4321 <= DOT_W'(r_p[3]) + DOT_W'(r_p[4]) + DOT_W'(r_p[5]);
        r_dots.d1321 <= DOT_W'(r_p[6]) + DOT_W'(r_p[7]) + DOT_W'(r_p[8]);
        r_dots.d4343 <= DOT_W'(r_p[9]) + DOT_W'(r_p[10]) + DOT_W'(r_p[11]);
        r_dots.d2121 <= DOT_W'(r_p[12]) + DOT_W'(r_p[13]) + DOT_W'(r_p[14]);
        r_st3 <= r_st2;
    end

    assign o_dots   = r_dots;
    assign o_status = r_st3;

endmodule

FILE: src/llcp_wmul.sv
module llcp_wmul import llcp_pkg::*; (
    input  logic  i_clk,
    input  t_dot  i_a,
    input  t_dot  i_b,
    output t_wide o_p
);

    logic [DOT_W-1:0] w_a_mag;
    logic [DOT_W-1:0] w_b_mag;
    logic [DOT_W-1:0] r_pp [4];
    logic             r_neg;
    logic [WIDE_W-1:0] w_sum;
    t_wide             r_p;

    // Magnitudes split in halves give four narrow partial products.
    always_comb begin
        w_a_mag = i_a[DOT_W-1] ? unsigned'(-i_a) : unsigned'(i_a);
        w_b_mag = i_b[DOT_W-1] ? unsigned'(-i_b) : unsigned'(i_b);
        w_sum = WIDE_W'(r_pp[0])
              + (WIDE_W'(r_pp[1]) << HALF_W)
              + (WIDE_W'(r_pp[2]) << HALF_W)
              + (WIDE_W'(r_pp[3]) << DOT_W);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                r_pp[2 * i + j] <= DOT_W'(w_a_mag[i * HALF_W +: HALF_W])
                                 * DOT_W'(w_b_mag[j * HALF_W +: HALF_W]);
            end
        end
        r_neg <= i_a[DOT_W-1] ^ i_b[DOT_W-1];
        r_p   <= r_neg ? signed'(-w_sum) : signed'(w_sum);
    end

    assign o_p = r_p;

endmodule

FILE: src/llcp_pmul.sv
module llcp_pmul import llcp_pkg::*; (
    input  logic               i_clk,
    input  logic [WIDE_W-1:0]  i_a,
    input  logic [DIFF_W-1:0]  i_b,
    output logic [PROD_W-1:0]  o_p
);

    localparam int PART_W = CHUNK_W + DIFF_W;

    logic [PART_W-1:0] r_pp [4];
    logic [PROD_W-1:0] w_sum;
    logic [PROD_W-1:0] r_p;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 4; i++) begin
            w_sum = w_sum + (PROD_W'(r_pp[i]) << (i * CHUNK_W));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_pp[i] <= PART_W'(i_a[i * CHUNK_W +: CHUNK_W]) * PART_W'(i_b);
        end
        r_p <= w_sum;
    end

    assign o_p = r_p;

endmodule

FILE: src/llcp_div.sv
module llcp_div import llcp_pkg::*; (
    input  logic              i_clk,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DVS_W-1:0]  i_dvs,
    output t_quo              o_quo
);

    logic [NUM_W-1:0] r_rem [0:QUO_W-1];
    logic [DVS_W-1:0] r_dv  [0:QUO_W-1];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    logic [NUM_W-1:0] w_sh   [0:QUO_W-1];
    logic             w_fits [0:QUO_W-1];

    // Stage j+1 decides quotient bit QUO_W-1-j against the shifted divisor.
    always_comb begin
        for (int j = 0; j < QUO_W; j++) begin
            w_sh[j]   = NUM_W'(r_dv[j]) << (QUO_W - 1 - j);
            w_fits[j] = r_rem[j] >= w_sh[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_dv[0]  <= i_dvs;
        r_q[0]   <= '0;
        // A quotient that does not fit in QUO_W bits only ever saturates.
        r_ovf[0] <= i_num >= (NUM_W'(i_dvs) << QUO_W);
        for (int k = 1; k <= QUO_W; k++) begin
            r_q[k]   <= r_q[k-1] | (w_fits[k-1] ? (QUO_W'(1) << (QUO_W - k)) : '0);
            r_ovf[k] <= r_ovf[k-1];
        end
        for (int k = 1; k < QUO_W; k++) begin
            r_rem[k] <= w_fits[k-1] ? r_rem[k-1] - w_sh[k-1] : r_rem[k-1];
            r_dv[k]  <= r_dv[k-1];
        end
    end

    assign o_quo.ovf = r_ovf[QUO_W];
    assign o_quo.q   = r_q[QUO_W];

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import llcp_pkg::*;

    typedef logic signed [255:0] t_big;

    typedef struct {
        t_in_item  item;
        logic      typed;
        t_out_item result;
    } t_vector;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_item;
    logic             i_cfg_we;
    logic [TOL_W-1:0] i_cfg_data;
    logic             o_valid;
    t_out_item        o_result;

    line_line_closest_points i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    logic [TOL_W-1:0] tol_copy;
    t_out_item        expected_points[$];
    int               n_beats;
    int               n_errors;
    int               quiet_cycles;
    int               idle_pct;
    logic             next_typed;
    t_out_item        next_result;
    t_vector          vectors[$];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic t_big round_div(input t_big n, input t_big d);
        t_big an;
        t_big ad;
        t_big q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_coord clamp_coord(input t_big v);
        t_big hi;
        t_big lo;
        hi = 256'sd2147483647;
        lo = -256'sd2147483648;
        if (v > hi) return 32'h7fff_ffff;
        if (v < lo) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic all_below(input t_big v[3], input logic [TOL_W-1:0] tol);
        t_big t;
        logic r;
        t = $signed({224'd0, tol});
        r = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (((v[i] < 0) ? -v[i] : v[i]) >= t) r = 1'b0;
        end
        return r;
    endfunction

    function automatic t_out_item closest_points(input t_in_item it,
                                                 input logic [TOL_W-1:0] tol);
        t_big as[3];
        t_big ae[3];
        t_big bs[3];
        t_big be[3];
        t_big d13[3];
        t_big d43[3];
        t_big d21[3];
        t_big d1343, d4321, d1321, d4343, d2121, den, na, nb, lim;
        t_out_item r;
        as = '{$signed(it.a_start_x), $signed(it.a_start_y), $signed(it.a_start_z)};
        ae = '{$signed(it.a_end_x), $signed(it.a_end_y), $signed(it.a_end_z)};
        bs = '{$signed(it.b_start_x), $signed(it.b_start_y), $signed(it.b_start_z)};
        be = '{$signed(it.b_end_x), $signed(it.b_end_y), $signed(it.b_end_z)};
        for (int i = 0; i < 3; i++) begin
            d13[i] = as[i] - bs[i];
            d43[i] = be[i] - bs[i];
            d21[i] = ae[i] - as[i];
        end
        r = '0;
        r.status = ST_OK;
        if (all_below(d43, tol)) begin
            r.status = ST_B_DEGEN;
            return r;
        end
        if (all_below(d21, tol)) begin
            r.status = ST_A_DEGEN;
            return r;
        end
        d1343 = d13[0] * d43[0] + d13[1] * d43[1] + d13[2] * d43[2];
        d4321 = d43[0] * d21[0] + d43[1] * d21[1] + d43[2] * d21[2];
        d1321 = d13[0] * d21[0] + d13[1] * d21[1] + d13[2] * d21[2];
        d4343 = d43[0] * d43[0] + d43[1] * d43[1] + d43[2] * d43[2];
        d2121 = d21[0] * d21[0] + d21[1] * d21[1] + d21[2] * d21[2];
        den   = d2121 * d4343 - d4321 * d4321;
        lim   = $signed({224'd0, tol}) <<< (3 * FRAC_BITS);
        if (den == 0 || ((den < 0) ? -den : den) < lim) begin
            r.status = ST_PARALLEL;
            return r;
        end
        na = d1343 * d4321 - d1321 * d4343;
        nb = d1343 * d2121 - d4321 * d1321;
        r.param_a  = clamp_coord(round_div(na <<< FRAC_BITS, den));
        r.param_b  = clamp_coord(round_div(nb <<< FRAC_BITS, den));
        r.near_a_x = clamp_coord(as[0] + round_div(na * d21[0], den));
        r.near_a_y = clamp_coord(as[1] + round_div(na * d21[1], den));
        r.near_a_z = clamp_coord(as[2] + round_div(na * d21[2], den));
        r.near_b_x = clamp_coord(bs[0] + round_div(nb * d43[0], den));
        r.near_b_y = clamp_coord(bs[1] + round_div(nb * d43[1], den));
        r.near_b_z = clamp_coord(bs[2] + round_div(nb * d43[2], den));
        return r;
    endfunction

    task automatic compare_points(input t_out_item e, input t_out_item g);
        if (g.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, g.status);
            n_errors++;
        end
        if (g.param_a !== e.param_a) begin
            $error("param_a expected %0d got %0d", e.param_a, g.param_a);
            n_errors++;
        end
        if (g.param_b !== e.param_b) begin
            $error("param_b expected %0d got %0d", e.param_b, g.param_b);
            n_errors++;
        end
        if (g.near_a_x !== e.near_a_x) begin
            $error("near_a_x expected %0d got %0d", e.near_a_x, g.near_a_x);
            n_errors++;
        end
        if (g.near_a_y !== e.near_a_y) begin
            $error("near_a_y expected %0d got %0d", e.near_a_y, g.near_a_y);
            n_errors++;
        end
        if (g.near_a_z !== e.near_a_z) begin
            $error("near_a_z expected %0d got %0d", e.near_a_z, g.near_a_z);
            n_errors++;
        end
        if (g.near_b_x !== e.near_b_x) begin
            $error("near_b_x expected %0d got %0d", e.near_b_x, g.near_b_x);
            n_errors++;
        end
        if (g.near_b_y !== e.near_b_y) begin
            $error("near_b_y expected %0d got %0d", e.near_b_y, g.near_b_y);
            n_errors++;
        end
        if (g.near_b_z !== e.near_b_z) begin
            $error("near_b_z expected %0d got %0d", e.near_b_z, g.near_b_z);
            n_errors++;
        end
    endtask

    // Input beats and result beats are both sampled here, ahead of the
    // nonblocking updates of the same edge.
    always @(posedge i_clk) begin
        quiet_cycles = quiet_cycles + 1;
        if (i_rst_n && start && !busy) begin
            expected_points.push_back(next_typed ? next_result
                                                 : closest_points(i_item, tol_copy));
            n_beats = n_beats + 1;
            quiet_cycles = 0;
        end
        if (i_rst_n && o_valid) begin
            quiet_cycles = 0;
            if (expected_points.size() == 0) begin
                $error("result beat with no expected result");
                n_errors++;
            end else begin
                compare_points(expected_points.pop_front(), o_result);
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input t_in_item it, input logic typed, input t_out_item res);
        int target;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        next_typed  = typed;
        next_result = res;
        target      = n_beats + 1;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        wait (n_beats >= target);
    endtask

    task automatic settle_and_write(input logic [TOL_W-1:0] value);
        start <= 1'b0;
        wait (expected_points.size() == 0);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tol_copy = value;
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    function automatic t_coord near_coord(input t_coord base, input logic [TOL_W-1:0] tol);
        int span;
        span = (tol > 32'd4096 || tol == 0) ? 4 : tol;
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_in_item random_pair(input logic [TOL_W-1:0] tol);
        t_in_item it;
        int scale;
        it.a_start_x = rand_coord();
        it.a_start_y = rand_coord();
        it.a_start_z = rand_coord();
        it.a_end_x   = rand_coord();
        it.a_end_y   = rand_coord();
        it.a_end_z   = rand_coord();
        it.b_start_x = rand_coord();
        it.b_start_y = rand_coord();
        it.b_start_z = rand_coord();
        it.b_end_x   = rand_coord();
        it.b_end_y   = rand_coord();
        it.b_end_z   = rand_coord();
        case ($urandom_range(9))
            0: begin
                it.b_end_x = near_coord(it.b_start_x, tol);
                it.b_end_y = near_coord(it.b_start_y, tol);
                it.b_end_z = near_coord(it.b_start_z, tol);
            end
            1: begin
                it.a_end_x = near_coord(it.a_start_x, tol);
                it.a_end_y = near_coord(it.a_start_y, tol);
                it.a_end_z = near_coord(it.a_start_z, tol);
            end
            2: begin
                // Second direction is a small multiple of the first, its x component off by at most one.
                scale = $urandom_range(3) + 1;
                it.a_start_x = $signed($urandom_range(32'h0010_0000));
                it.a_start_y = $signed($urandom_range(32'h0010_0000));
                it.a_start_z = $signed($urandom_range(32'h0010_0000));
                it.a_end_x = it.a_start_x + $signed($urandom_range(32'h0004_0000));
                it.a_end_y = it.a_start_y + $signed($urandom_range(32'h0004_0000));
                it.a_end_z = it.a_start_z + $signed($urandom_range(32'h0004_0000));
                it.b_start_x = $signed($urandom_range(32'h0010_0000));
                it.b_start_y = $signed($urandom_range(32'h0010_0000));
                it.b_start_z = $signed($urandom_range(32'h0010_0000));
                it.b_end_x = it.b_start_x + scale * (it.a_end_x - it.a_start_x)
                             + $signed($urandom_range(2)) - 1;
                it.b_end_y = it.b_start_y + scale * (it.a_end_y - it.a_start_y);
                it.b_end_z = it.b_start_z + scale * (it.a_end_z - it.a_start_z);
            end
            default: ;
        endcase
        return it;
    endfunction

    function automatic t_in_item make_pair(input t_coord ax, ay, az, bx, by, bz,
                                           input t_coord cx, cy, cz, ex, ey, ez);
        t_in_item it;
        it = '{ax, ay, az, bx, by, bz, cx, cy, cz, ex, ey, ez};
        return it;
    endfunction

    task automatic add_vector(input t_in_item it, input logic typed, input t_out_item res);
        t_vector v;
        v.item   = it;
        v.typed  = typed;
        v.result = res;
        vectors.push_back(v);
    endtask

    initial begin
        t_out_item        r;
        logic [TOL_W-1:0] tols[6];
        t_coord           mx;
        t_coord           mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        tols = '{32'd1, 32'd0, 32'hffff_ffff, 32'h0001_0000, 32'd300, 32'd1};
        start        = 1'b0;
        i_item       = '0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        tol_copy     = 32'd1;
        n_beats      = 0;
        n_errors     = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        next_typed   = 1'b0;
        next_result  = '0;

        r = '0;
        r.status = ST_B_DEGEN;
        add_vector('0, 1'b1, r);
        r.status = ST_A_DEGEN;
        add_vector(make_pair(5, 5, 5, 5, 5, 5, 0, 0, 0, 65536, 0, 0), 1'b1, r);
        r.status = ST_PARALLEL;
        add_vector(make_pair(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 131072, 65536, 0),
                   1'b1, r);
        r = '0;
        r.status   = ST_OK;
        r.param_b  = -32'sd65536;
        r.near_b_y = 32'sd65536;
        add_vector(make_pair(0, 0, 0, 65536, 0, 0, 0, 65536, 65536, 0, 65536, 131072),
                   1'b1, r);
        add_vector(make_pair(mn, mn, mn, mx, mx, mx, mx, mn, mn, mn, mx, mx), 1'b0, r);
        add_vector(make_pair(mx, mx, mx, mn, mn, mn, mn, mx, mn, mx, mn, mx), 1'b0, r);
        add_vector(make_pair(mn, 0, 0, mx, 1, 0, 0, mn, 7, 0, mx, -7), 1'b0, r);
        add_vector(make_pair(0, 0, 0, 1, 0, 0, 9, 3, 0, 9, 3, 1), 1'b0, r);
        add_vector(make_pair(0, 0, 0, 2, 0, 0, 0, 5, 0, 0, 5, 1), 1'b0, r);
        add_vector(make_pair(0, 0, 0, 65536, 1, 0, 0, 0, 65536, 1, 0, 65536), 1'b0, r);
        add_vector(make_pair(-1, -1, -1, 0, 0, 0, 0, 0, 0, 1, 1, 1), 1'b0, r);
        add_vector(make_pair(100, 200, 300, 65636, 200, 300,
                             mx, 0, 0, mx, 65536, 0), 1'b0, r);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (vectors[i]) send_item(vectors[i].item, vectors[i].typed, vectors[i].result);

        for (int p = 0; p < 6; p++) begin
            settle_and_write(tols[p]);
            for (int n = 0; n < 250; n++) begin
                case (n / 63)
                    0: idle_pct = 0;
                    1: idle_pct = 76;
                    2: idle_pct = 0;
                    default: idle_pct = 10;
                endcase
                send_item(random_pair(tol_copy), 1'b0, '0);
            end
        end

        start <= 1'b0;
        wait (expected_points.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/llcp_pkg.sv
src/llcp_dots.sv
src/llcp_wmul.sv
src/llcp_pmul.sv
src/llcp_div.sv
src/line_line_closest_points.sv
bench/tb_top.sv
